// ===== rtl/cht_pkg.sv =====
// Package for the chained hash table: field widths, status and mode codes,
// sequencer state type and remainder unit sizing.
// No dependencies; imported by cht_mod and chained_hash_table.
package cht_pkg;

   // Field widths fixed by the transaction format
   localparam int MODE_W   = 1;
   localparam int KEY_W    = 31;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 3;
   localparam int CSR_W    = 8;

   // Bucket count after reset
   localparam logic [CSR_W-1:0] BUCKET_COUNT_RESET = 8'd101;

   // Operation codes
   localparam logic [MODE_W-1:0] MODE_INSERT = 1'b0;
   localparam logic [MODE_W-1:0] MODE_FIND   = 1'b1;

   // Response status codes
   localparam logic [STATUS_W-1:0] STATUS_INSERTED = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_UPDATED  = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_FOUND    = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_MISSING  = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_FULL     = 3'd4;

   // Remainder unit: key padded to an even width, two quotient bits per cycle
   localparam int DIV_W    = KEY_W + (KEY_W % 2);
   localparam int DIV_STEPS = DIV_W / 2;
   localparam int STEP_W   = $clog2(DIV_STEPS);

   // Sequencer states
   typedef enum logic [2:0] {
      ST_CLEAR,   // sweep bucket heads to empty after reset
      ST_IDLE,    // wait for a transaction
      ST_MOD,     // remainder unit running
      ST_HEAD,    // bucket head read in flight
      ST_LOAD,    // take chain head as current node
      ST_CHECK,   // end of chain test, node read issued
      ST_CMP      // compare node key, follow link
   } state_type;

endpackage

// ===== rtl/cht_mod.sv =====
// Iterative remainder unit: key modulo bucket count, restoring division,
// two bits per cycle. Depends on cht_pkg.
module cht_mod (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [cht_pkg::KEY_W-1:0] dividend,
   input  logic [cht_pkg::CSR_W-1:0] divisor,
   output logic                      done,
   output logic [cht_pkg::CSR_W-1:0] remainder
);
   import cht_pkg::*;

   logic                run_ff,   run_in;
   logic                done_ff,  done_in;
   logic [STEP_W-1:0]   cnt_ff,   cnt_in;
   logic [DIV_W-1:0]    shift_ff, shift_in;
   logic [CSR_W-1:0]    rem_ff,   rem_in;
   logic [CSR_W-1:0]    div_ff,   div_in;
   logic [CSR_W-1:0]    rem_mid;

   // One restoring step: shift in a bit, subtract divisor if it fits
   function automatic logic [CSR_W-1:0] rem_step(input logic [CSR_W-1:0] r,
                                                 input logic b,
                                                 input logic [CSR_W-1:0] d);
      logic [CSR_W:0] t;
      t = {r, b};
      if (t >= {1'b0, d}) begin
         t = t - {1'b0, d};
      end
      return t[CSR_W-1:0];
   endfunction

   // Next state: load on start, then two steps per cycle
   always_comb begin
      run_in   = run_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      shift_in = shift_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      rem_mid  = rem_step(rem_ff, shift_ff[DIV_W-1], div_ff);
      if (start) begin
         run_in   = 1'b1;
         cnt_in   = '0;
         shift_in = DIV_W'(dividend);
         rem_in   = '0;
         div_in   = divisor;
      end else if (run_ff) begin
         rem_in   = rem_step(rem_mid, shift_ff[DIV_W-2], div_ff);
         shift_in = {shift_ff[DIV_W-3:0], 2'b00};
         cnt_in   = cnt_ff + 1'b1;
         if (cnt_ff == STEP_W'(DIV_STEPS - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      cnt_ff   <= cnt_in;
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
      div_ff   <= div_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

// ===== rtl/chained_hash_table.sv =====
// Hash map with separate chaining: bucket head table, node pool and
// sequencer. Depends on cht_pkg and cht_mod.
//
// A transaction is taken when start is high and busy is low; its response
// appears on the rsp_ ports for one cycle with rsp_strobe and cannot be held
// off. A transaction runs the two-bit-per-cycle remainder unit, then reads the
// bucket head and walks the chain; every node visited costs one node-memory
// read plus one key compare. After reset the block clears the bucket head
// memory, one entry a cycle, with busy high; csr writes are taken meanwhile.
// The user must write the bucket count register only while busy is low and
// no response is pending; the block itself does not enforce this. A full pool
// drops a new key with status pool full.
module chained_hash_table #(
   parameter int BUCKETS = 128,
   parameter int NODES   = 256
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [cht_pkg::MODE_W-1:0]   req_mode,
   input  logic [cht_pkg::KEY_W-1:0]    req_key,
   input  logic [cht_pkg::VALUE_W-1:0]  req_value,
   input  logic                         csr_wr_en,
   input  logic [cht_pkg::CSR_W-1:0]    csr_wr_data,
   output logic                         rsp_strobe,
   output logic [cht_pkg::STATUS_W-1:0] rsp_status,
   output logic [cht_pkg::VALUE_W-1:0]  rsp_found_value,
   output logic [$clog2(NODES+1)-1:0]   rsp_entry_count
);
   import cht_pkg::*;

   localparam int LINK_W = $clog2(NODES + 1);
   localparam int NODE_W = (NODES > 1) ? $clog2(NODES) : 1;
   localparam int BKT_W  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(NODES);

   // Memories
   logic [LINK_W-1:0]  head_mem [BUCKETS];
   logic [KEY_W-1:0]   key_mem  [NODES];
   logic [VALUE_W-1:0] val_mem  [NODES];
   logic [LINK_W-1:0]  next_mem [NODES];

   // Registers
   state_type          state_ff, state_in;
   logic [CSR_W-1:0]   bcount_ff, bcount_in;
   logic [MODE_W-1:0]  mode_ff, mode_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic [VALUE_W-1:0] value_ff, value_in;
   logic [BKT_W-1:0]   bucket_ff, bucket_in;
   logic [BKT_W-1:0]   clr_ff, clr_in;
   logic [LINK_W-1:0]  at_ff, at_in;
   logic [LINK_W-1:0]  used_ff, used_in;
   logic               rsp_strobe_ff, rsp_strobe_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic [LINK_W-1:0]  rsp_count_ff, rsp_count_in;

   // Memory read data
   logic [LINK_W-1:0]  head_rd_ff;
   logic [KEY_W-1:0]   nkey_rd_ff;
   logic [VALUE_W-1:0] nval_rd_ff;
   logic [LINK_W-1:0]  nnext_rd_ff;

   // Memory write controls
   logic               head_we;
   logic [BKT_W-1:0]   head_waddr;
   logic [LINK_W-1:0]  head_wdata;
   logic               node_we;
   logic               val_we;
   logic [NODE_W-1:0]  val_waddr;

   // Remainder unit
   logic               mod_start;
   logic               mod_done;
   logic [CSR_W-1:0]   mod_rem;
   logic [CSR_W-1:0]   eff_count;
   logic               accept;

   // Bucket count in use: zero acts as one, clamp to table size
   always_comb begin
      if (bcount_ff == '0) begin
         eff_count = CSR_W'(1);
      end else if (32'(bcount_ff) > BUCKETS) begin
         eff_count = CSR_W'(BUCKETS);
      end else begin
         eff_count = bcount_ff;
      end
   end

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   cht_mod u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (req_key),
      .divisor   (eff_count),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   // Sequencer: next state, memory writes, response
   always_comb begin
      state_in      = state_ff;
      bcount_in     = csr_wr_en ? csr_wr_data : bcount_ff;
      mode_in       = mode_ff;
      key_in        = key_ff;
      value_in      = value_ff;
      bucket_in     = bucket_ff;
      clr_in        = clr_ff;
      at_in         = at_ff;
      used_in       = used_ff;
      rsp_strobe_in = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = '0;
      rsp_count_in  = used_ff;
      head_we       = 1'b0;
      head_waddr    = bucket_ff;
      head_wdata    = used_ff;
      node_we       = 1'b0;
      val_we        = 1'b0;
      val_waddr     = at_ff[NODE_W-1:0];
      mod_start     = 1'b0;

      case (state_ff)
         ST_CLEAR: begin
            head_we    = 1'b1;
            head_waddr = clr_ff;
            head_wdata = NULL_LINK;
            clr_in     = clr_ff + 1'b1;
            if (clr_ff == BKT_W'(BUCKETS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               mod_start = 1'b1;
               mode_in   = req_mode;
               key_in    = req_key;
               value_in  = req_value;
               state_in  = ST_MOD;
            end
         end
         ST_MOD: begin
            if (mod_done) begin
               bucket_in = BKT_W'(mod_rem);
               state_in  = ST_HEAD;
            end
         end
         ST_HEAD: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            at_in    = head_rd_ff;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            // links always point to older nodes, so every chain ends
            if (at_ff == NULL_LINK) begin
               rsp_strobe_in = 1'b1;
               state_in      = ST_IDLE;
               if (mode_ff == MODE_FIND) begin
                  rsp_status_in = STATUS_MISSING;
               end else if (used_ff == NULL_LINK) begin
                  rsp_status_in = STATUS_FULL;
               end else begin
                  // prepend a fresh node to the chain
                  node_we       = 1'b1;
                  head_we       = 1'b1;
                  used_in       = used_ff + 1'b1;
                  rsp_count_in  = used_ff + 1'b1;
                  rsp_status_in = STATUS_INSERTED;
               end
            end else begin
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            if (nkey_rd_ff == key_ff) begin
               rsp_strobe_in = 1'b1;
               state_in      = ST_IDLE;
               if (mode_ff == MODE_FIND) begin
                  rsp_status_in = STATUS_FOUND;
                  rsp_value_in  = nval_rd_ff;
               end else begin
                  val_we        = 1'b1;
                  rsp_status_in = STATUS_UPDATED;
               end
            end else begin
               at_in    = nnext_rd_ff;
               state_in = ST_CHECK;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (node_we) begin
         val_waddr = used_ff[NODE_W-1:0];
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         bcount_ff     <= BUCKET_COUNT_RESET;
         clr_ff        <= '0;
         used_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         bcount_ff     <= bcount_in;
         clr_ff        <= clr_in;
         used_ff       <= used_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Transaction and response payload
   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      key_ff        <= key_in;
      value_ff      <= value_in;
      bucket_ff     <= bucket_in;
      at_ff         <= at_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_count_ff  <= rsp_count_in;
   end

   // Bucket head memory
   always_ff @(posedge clock) begin
      if (head_we) begin
         head_mem[head_waddr] <= head_wdata;
      end
      head_rd_ff <= head_mem[bucket_ff];
   end

   // Node pool memories
   always_ff @(posedge clock) begin
      if (node_we) begin
         key_mem[used_ff[NODE_W-1:0]]  <= key_ff;
         next_mem[used_ff[NODE_W-1:0]] <= head_rd_ff;
      end
      if (node_we || val_we) begin
         val_mem[val_waddr] <= value_ff;
      end
      nkey_rd_ff  <= key_mem[at_ff[NODE_W-1:0]];
      nval_rd_ff  <= val_mem[at_ff[NODE_W-1:0]];
      nnext_rd_ff <= next_mem[at_ff[NODE_W-1:0]];
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_found_value = rsp_value_ff;
   assign rsp_entry_count = rsp_count_ff;

   // Accepted transaction starts the remainder unit
   a_accept_mod: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_MOD))
      else $error("accepted transaction did not enter remainder phase");

   // Pool count never passes the pool size
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= NULL_LINK)
      else $error("node count beyond pool size");

   // A walked link always names a node already allocated
   a_link_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHECK && at_ff != NULL_LINK) |-> (at_ff < used_ff))
      else $error("chain link to unallocated node");

   // Only a find hit returns a value
   a_value_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status != STATUS_FOUND) |-> (rsp_found_value == '0))
      else $error("nonzero value on response other than found");

   // Responses come only out of the walk
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ($past(state_ff) == ST_CHECK || $past(state_ff) == ST_CMP))
      else $error("response outside chain walk");

endmodule
